/* design/vt_pkg.sv */
package vt_pkg;

    localparam int PARAM_SLOTS_DEF = 5;
    localparam int PARAM_WIDTH_DEF = 16;
    localparam int OUT_PARAMS      = 5;

    localparam logic [2:0] TK_PRINT   = 3'd0;
    localparam logic [2:0] TK_CONTROL = 3'd1;
    localparam logic [2:0] TK_ESCAPE  = 3'd2;
    localparam logic [2:0] TK_CSI     = 3'd3;
    localparam logic [2:0] TK_CHARSET = 3'd4;

    localparam logic [7:0] CH_BEL     = 8'h07;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_EIGHT   = 8'h38;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] FINAL_LO   = 8'h40;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_J       = 8'h4A;
    localparam logic [7:0] CH_K       = 8'h4B;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_Z       = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_LOWER_C = 8'h63;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;
    localparam logic [7:0] FINAL_END  = 8'h7E;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_word_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  token_code;
        logic [15:0] param_a;
        logic [15:0] param_b;
        logic [15:0] param_c;
        logic [15:0] param_d;
        logic [15:0] param_e;
        logic [2:0]  separator_count;
        logic        private_flag;
        logic        space_flag;
        logic        vt52_active;
    } token_word_t;

    typedef struct packed {
        logic       clear;
        logic       digit_en;
        logic       sep_en;
        logic [3:0] digit;
    } param_ctl_t;

endpackage

/* design/vt_stream_if.sv */
interface vt_stream_if #(
    parameter type word_t = logic [7:0]
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/vt_param_bank.sv */
// Holds the CSI parameter slots and the current slot index. Each slot does its
// own saturating decimal accumulate when it is the current one.
module vt_param_bank
    import vt_pkg::*;
#(
    parameter int PARAM_SLOTS = PARAM_SLOTS_DEF,
    parameter int PARAM_WIDTH = PARAM_WIDTH_DEF,
    localparam int IDX_W      = $clog2(PARAM_SLOTS + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  param_ctl_t                              ctl,
    output logic [PARAM_SLOTS-1:0][PARAM_WIDTH-1:0] store,
    output logic [IDX_W-1:0]                        index
);

    localparam int ACC_W = PARAM_WIDTH + 4;
    localparam logic [ACC_W-1:0] ACC_MAX = {4'b0, {PARAM_WIDTH{1'b1}}};

    logic [PARAM_SLOTS-1:0][PARAM_WIDTH-1:0] store_reg;
    logic [PARAM_SLOTS-1:0][PARAM_WIDTH-1:0] store_next;
    logic [IDX_W-1:0]                        index_reg;
    logic [IDX_W-1:0]                        index_next;

    genvar i;
    generate
        for (i = 0; i < PARAM_SLOTS; i++) begin : g_slot
            logic [ACC_W-1:0] wide;
            logic [ACC_W-1:0] acc;

            assign wide = {4'b0, store_reg[i]};
            assign acc  = (wide << 3) + (wide << 1) + {{(ACC_W-4){1'b0}}, ctl.digit};

            always_comb
            begin
                store_next[i] = store_reg[i];
                if (ctl.clear)
                begin
                    store_next[i] = '0;
                end
                else if (ctl.digit_en && index_reg == IDX_W'(i))
                begin
                    store_next[i] = (acc > ACC_MAX) ? {PARAM_WIDTH{1'b1}}
                                                    : acc[PARAM_WIDTH-1:0];
                end
            end
        end
    endgenerate

    always_comb
    begin
        index_next = index_reg;
        if (ctl.clear)
        begin
            index_next = '0;
        end
        else if (ctl.sep_en && index_reg < IDX_W'(PARAM_SLOTS))
        begin
            index_next = index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            store_reg <= store_next;
            index_reg <= index_next;
        end
    end

    assign store = store_reg;
    assign index = index_reg;

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= IDX_W'(PARAM_SLOTS))
        else $error("parameter slot index beyond the last slot");

    a_clear_index: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> index_reg == '0)
        else $error("slot index not cleared at end of sequence");

    a_sep_step: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.clear && ctl.sep_en && index_reg < IDX_W'(PARAM_SLOTS)
        |=> index_reg == $past(index_reg) + 1'b1)
        else $error("separator did not advance the slot index");

endmodule

/* design/vt100_escape_sequence_parser.sv */
// Channel  Dir  Word          Contents
// rx       in   rx_word_t     one received byte
// tok      out  token_word_t  decoded token: kind, code, five parameters, flags, mode
//
// One byte is taken each cycle that rx.ready is high; its token, if any, appears
// in the output register on the next cycle.
// Parse state and slots are registered along with the token when a byte is taken.
// A byte is taken while the output register is empty or being read, so a stalled
// output holds rx back only when a token is already waiting.
// Reset clears the parse state, the parameter slots and selects VT100 mode.
module vt100_escape_sequence_parser
    import vt_pkg::*;
#(
    parameter int PARAM_SLOTS = PARAM_SLOTS_DEF,
    parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vt_stream_if.sink   rx,
    vt_stream_if.source tok
);

    localparam int IDX_W = $clog2(PARAM_SLOTS + 1);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ESC     = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        question_reg;
    logic        question_next;
    logic        space_reg;
    logic        space_next;
    logic        charset_reg;
    logic        charset_next;
    logic        vt52_reg;
    logic        vt52_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    token_word_t out_data_reg;
    token_word_t out_data_next;

    param_ctl_t                              ctl;
    logic [PARAM_SLOTS-1:0][PARAM_WIDTH-1:0] store;
    logic [IDX_W-1:0]                        index;
    logic [OUT_PARAMS-1:0][15:0]             par16;

    logic       accept;
    logic [7:0] b;
    logic       is_digit;
    logic       is_final;
    logic       esc_hit;
    logic       emit;
    logic       full;
    logic [2:0] kind;

    assign accept = rx.valid && rx.ready;
    assign b      = rx.data.rx_byte;
    assign rx.ready = !out_valid_reg || tok.ready;

    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_final = (b >= FINAL_LO) && (b < FINAL_END);

    always_comb
    begin
        if (b == CH_LOWER_C || b == CH_F || b == CH_G)
        begin
            esc_hit = 1'b1;
        end
        else if (!vt52_reg)
        begin
            esc_hit = (b == CH_SEVEN) || (b == CH_EIGHT) || (b == CH_D) ||
                      (b == CH_M) || (b == CH_E);
        end
        else
        begin
            esc_hit = (b == CH_A) || (b == CH_B) || (b == CH_C) || (b == CH_D) ||
                      (b == CH_H) || (b == CH_I) || (b == CH_J) || (b == CH_K) ||
                      (b == CH_Z) || (b == CH_LESS);
        end
    end

    genvar i;
    generate
        for (i = 0; i < OUT_PARAMS; i++) begin : g_out
            if (i < PARAM_SLOTS) begin : g_used
                assign par16[i] = 16'(store[i]);
            end
            else begin : g_absent
                assign par16[i] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        phase_next    = phase_reg;
        question_next = question_reg;
        space_next    = space_reg;
        charset_next  = charset_reg;
        vt52_next     = vt52_reg;
        ctl           = '{clear: 1'b0, digit_en: 1'b0, sep_en: 1'b0,
                          digit: b[3:0]};
        emit          = 1'b0;
        full          = 1'b0;
        kind          = TK_PRINT;

        case (phase_reg)
            PH_ESC:
            begin
                ctl.clear     = 1'b1;
                question_next = 1'b0;
                space_next    = 1'b0;
                if (b == CH_LBRACK || b == CH_LPAREN)
                begin
                    phase_next   = PH_COLLECT;
                    charset_next = (b == CH_LPAREN);
                end
                else
                begin
                    phase_next   = PH_IDLE;
                    charset_next = 1'b0;
                    emit         = esc_hit;
                    kind         = TK_ESCAPE;
                    if (b == CH_LOWER_C || (vt52_reg && b == CH_LESS))
                    begin
                        vt52_next = 1'b0;
                    end
                end
            end
            PH_COLLECT:
            begin
                if (is_digit && !charset_reg)
                begin
                    ctl.digit_en = 1'b1;
                end
                else if (is_digit || is_final)
                begin
                    ctl.clear     = 1'b1;
                    question_next = 1'b0;
                    space_next    = 1'b0;
                    charset_next  = 1'b0;
                    phase_next    = PH_IDLE;
                    if (charset_reg)
                    begin
                        emit = 1'b1;
                        kind = TK_CHARSET;
                    end
                    else if (!vt52_reg)
                    begin
                        emit = 1'b1;
                        full = 1'b1;
                        kind = TK_CSI;
                        if (question_reg && store[0] == PARAM_WIDTH'(2) &&
                            b == CH_LOWER_L)
                        begin
                            vt52_next = 1'b1;
                        end
                        if (question_reg && store[0] == PARAM_WIDTH'(9) &&
                            (b == CH_LOWER_H || b == CH_LOWER_L))
                        begin
                            vt52_next = 1'b0;
                        end
                    end
                    else
                    begin
                        emit = (b == CH_Z);
                        full = 1'b1;
                        kind = TK_CSI;
                    end
                end
                else if (b == CH_SEMI)
                begin
                    ctl.sep_en = 1'b1;
                end
                else if (b == CH_QUEST)
                begin
                    question_next = 1'b1;
                end
                else if (b == CH_SPACE)
                begin
                    space_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (b >= CH_SPACE)
                begin
                    emit = 1'b1;
                    kind = TK_PRINT;
                end
                else if (b == CH_ESC)
                begin
                    phase_next = PH_ESC;
                end
                else if (b == CH_BEL || b == CH_BS || b == CH_LF || b == CH_FF ||
                         b == CH_CR)
                begin
                    emit = 1'b1;
                    kind = TK_CONTROL;
                end
            end
        endcase

        if (!accept)
        begin
            phase_next    = phase_reg;
            question_next = question_reg;
            space_next    = space_reg;
            charset_next  = charset_reg;
            vt52_next     = vt52_reg;
            ctl.clear     = 1'b0;
            ctl.digit_en  = 1'b0;
            ctl.sep_en    = 1'b0;
            emit          = 1'b0;
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next.token_kind  = kind;
        out_data_next.token_code  = b;
        out_data_next.vt52_active = vt52_reg;
        if (full)
        begin
            out_data_next.param_a         = par16[0];
            out_data_next.param_b         = par16[1];
            out_data_next.param_c         = par16[2];
            out_data_next.param_d         = par16[3];
            out_data_next.param_e         = par16[4];
            out_data_next.separator_count = 3'(index);
            out_data_next.private_flag    = question_reg;
            out_data_next.space_flag      = space_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = emit;
        end
        else if (tok.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    vt_param_bank #(
        .PARAM_SLOTS (PARAM_SLOTS),
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_params (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .store (store),
        .index (index)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            question_reg  <= 1'b0;
            space_reg     <= 1'b0;
            charset_reg   <= 1'b0;
            vt52_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            question_reg  <= question_next;
            space_reg     <= space_next;
            charset_reg   <= charset_next;
            vt52_reg      <= vt52_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign tok.valid = out_valid_reg;
    assign tok.data  = out_data_reg;

    a_esc_opens: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_IDLE && b == CH_ESC |=> phase_reg == PH_ESC)
        else $error("ESC in idle did not open a sequence");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !tok.ready |-> !rx.ready)
        else $error("byte taken while a token waits unread");

    a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.token_kind != TK_CSI
        |-> out_data_reg.separator_count == 3'd0 && !out_data_reg.private_flag &&
            !out_data_reg.space_flag && out_data_reg.param_a == 16'd0)
        else $error("non-CSI token carries CSI fields");

    a_vt52_csi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.token_kind == TK_CSI && out_data_reg.vt52_active
        |-> out_data_reg.token_code == CH_Z)
        else $error("CSI token other than Z emitted in VT52 mode");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import vt_pkg::*;

    localparam int SLOT_COUNT  = PARAM_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_COLLECT
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    vt_stream_if #(.word_t(rx_word_t))    rx_if ();
    vt_stream_if #(.word_t(token_word_t)) tok_if ();

    vt100_escape_sequence_parser i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tok   (tok_if)
    );

    always #5 clk = ~clk;

    parse_phase_t phase;
    logic [15:0]  param_slots [SLOT_COUNT];
    logic [2:0]   slot_index;
    logic         question_seen;
    logic         space_seen;
    logic         charset_open;
    logic         vt52_mode;

    token_word_t  pending_tokens [$];
    int           error_count = 0;
    int           item_count = 0;
    int           cycle_count = 0;
    bit           no_idle = 1'b0;

    function automatic void clear_sequence();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            param_slots[i] = '0;
        end
        slot_index    = '0;
        question_seen = 1'b0;
        space_seen    = 1'b0;
        charset_open  = 1'b0;
        phase         = PH_IDLE;
    endfunction

    function automatic bit finish_sequence(input logic [7:0] b, output token_word_t t);
        logic mode;
        bit   hit;
        mode = vt52_mode;
        hit  = 1'b0;
        t    = '0;
        if (charset_open)
        begin
            hit = 1'b1;
            t.token_kind = TK_CHARSET;
        end
        else if (!mode || b == CH_Z)
        begin
            hit = 1'b1;
            t.token_kind      = TK_CSI;
            t.param_a         = param_slots[0];
            t.param_b         = param_slots[1];
            t.param_c         = param_slots[2];
            t.param_d         = param_slots[3];
            t.param_e         = param_slots[4];
            t.separator_count = slot_index;
            t.private_flag    = question_seen;
            t.space_flag      = space_seen;
            if (!mode && question_seen && param_slots[0] == 16'd2 && b == CH_LOWER_L)
            begin
                vt52_mode = 1'b1;
            end
            if (!mode && question_seen && param_slots[0] == 16'd9 &&
                (b == CH_LOWER_H || b == CH_LOWER_L))
            begin
                vt52_mode = 1'b0;
            end
        end
        t.token_code  = b;
        t.vt52_active = mode;
        clear_sequence();
        return hit;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output token_word_t t);
        logic        mode;
        bit          hit;
        logic [31:0] acc;
        t    = '0;
        hit  = 1'b0;
        mode = vt52_mode;
        case (phase)
            PH_ESC:
            begin
                if (b == CH_LBRACK || b == CH_LPAREN)
                begin
                    clear_sequence();
                    phase        = PH_COLLECT;
                    charset_open = (b == CH_LPAREN);
                    return 1'b0;
                end
                if (b == CH_LOWER_C)
                begin
                    vt52_mode = 1'b0;
                    hit = 1'b1;
                end
                else if (b == CH_F || b == CH_G)
                begin
                    hit = 1'b1;
                end
                else if (!mode)
                begin
                    hit = (b == CH_SEVEN || b == CH_EIGHT || b == CH_D ||
                           b == CH_M || b == CH_E);
                end
                else
                begin
                    hit = (b == CH_A || b == CH_B || b == CH_C || b == CH_D ||
                           b == CH_H || b == CH_I || b == CH_J || b == CH_K ||
                           b == CH_Z || b == CH_LESS);
                    if (b == CH_LESS)
                    begin
                        vt52_mode = 1'b0;
                    end
                end
                clear_sequence();
                t.token_kind  = TK_ESCAPE;
                t.token_code  = b;
                t.vt52_active = mode;
                return hit;
            end
            PH_COLLECT:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    if (charset_open)
                    begin
                        return finish_sequence(b, t);
                    end
                    if (slot_index < SLOT_COUNT)
                    begin
                        acc = 32'(param_slots[slot_index]);
                        acc = acc * 10 + 32'(b - CH_ZERO);
                        param_slots[slot_index] = (acc > 32'hFFFF) ? 16'hFFFF : acc[15:0];
                    end
                end
                else if (b == CH_SEMI)
                begin
                    if (slot_index < SLOT_COUNT)
                    begin
                        slot_index = slot_index + 3'd1;
                    end
                end
                else if (b == CH_QUEST)
                begin
                    question_seen = 1'b1;
                end
                else if (b == CH_SPACE)
                begin
                    space_seen = 1'b1;
                end
                else if (b >= FINAL_LO && b < FINAL_END)
                begin
                    return finish_sequence(b, t);
                end
                return 1'b0;
            end
            default:
            begin
                phase = PH_IDLE;
                t.vt52_active = mode;
                t.token_code  = b;
                if (b >= CH_SPACE)
                begin
                    t.token_kind = TK_PRINT;
                    return 1'b1;
                end
                if (b == CH_ESC)
                begin
                    phase = PH_ESC;
                    return 1'b0;
                end
                t.token_kind = TK_CONTROL;
                return (b == CH_BEL || b == CH_BS || b == CH_LF || b == CH_FF || b == CH_CR);
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int          gap;
        token_word_t t;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid        <= 1'b1;
        rx_if.data.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        if (decode_byte(b, t))
        begin
            pending_tokens.push_back(t);
        end
        item_count++;
    endtask

    task automatic send_number(input int unsigned value);
        logic [7:0] digits [10];
        int         n;
        n = 0;
        do
        begin
            digits[n] = CH_ZERO + 8'(value % 10);
            value     = value / 10;
            n++;
        end
        while (value != 0);
        for (int i = n - 1; i >= 0; i--)
        begin
            send_byte(digits[i]);
        end
    endtask

    task automatic test_plain_bytes();
        send_byte(CH_SPACE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_BEL);
        send_byte(CH_LF);
        send_byte(8'h1F);
    endtask

    task automatic test_vt100_escapes();
        send_byte(CH_ESC);
        send_byte(CH_SEVEN);
        send_byte(CH_ESC);
        send_byte(CH_A);
        send_byte(CH_ESC);
        send_byte(CH_LPAREN);
        send_byte(CH_ZERO);
        send_byte(CH_ESC);
        send_byte(CH_LPAREN);
        send_byte(CH_B);
    endtask

    task automatic test_csi_params();
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_QUEST);
        send_number(99999);
        send_byte(CH_SEMI);
        send_number(65535);
        for (int i = 0; i < 5; i++)
        begin
            send_byte(CH_SEMI);
        end
        send_byte(CH_NINE);
        send_byte(CH_ESC);
        send_byte(CH_SPACE);
        send_byte(8'h7D);
    endtask

    function automatic logic [7:0] CH_FINAL_M();
        return CH_M + 8'h20;
    endfunction

    task automatic test_mode_switch();
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_QUEST);
        send_byte(8'h32);
        send_byte(CH_LOWER_L);
        send_byte(CH_ESC);
        send_byte(CH_A);
        send_byte(CH_ESC);
        send_byte(CH_SEVEN);
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_FINAL_M());
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_Z);
        send_byte(CH_ESC);
        send_byte(CH_LESS);
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_QUEST);
        send_byte(8'h32);
        send_byte(CH_LOWER_L);
        send_byte(CH_ESC);
        send_byte(CH_LOWER_C);
        send_byte(8'h7E);
    endtask

    task automatic send_csi();
        int         np;
        int         style;
        logic [7:0] b;
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        case ($urandom_range(0, 9))
            0:
            begin
                send_byte(CH_QUEST);
                send_number(2);
                send_byte(CH_LOWER_L);
            end
            1:
            begin
                send_byte(CH_QUEST);
                send_number(9);
                send_byte($urandom_range(0, 1) ? CH_LOWER_H : CH_LOWER_L);
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_byte(CH_QUEST);
                end
                np = $urandom_range(0, 7);
                for (int i = 0; i < np; i++)
                begin
                    if (i > 0)
                    begin
                        send_byte(CH_SEMI);
                    end
                    style = $urandom_range(0, 9);
                    case (style)
                        0: ;
                        1: send_number(65535);
                        2: send_number(65536);
                        3: send_number($urandom);
                        4, 5, 6: send_number($urandom_range(0, 9));
                        default: send_number($urandom_range(0, 999));
                    endcase
                    if ($urandom_range(0, 11) == 0)
                    begin
                        do b = 8'($urandom_range(0, 255));
                        while (b >= CH_ZERO && b < FINAL_END);
                        send_byte(b);
                    end
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    send_byte(CH_SPACE);
                end
                case ($urandom_range(0, 5))
                    0: send_byte(CH_Z);
                    1: send_byte(CH_LOWER_L);
                    default: send_byte(8'($urandom_range(FINAL_LO, 8'h7D)));
                endcase
            end
        endcase
    endtask

    task automatic test_random_traffic();
        int         next_switch;
        int         n;
        logic [7:0] b;
        next_switch = 0;
        while (item_count < RANDOM_ITEMS)
        begin
            if (item_count >= next_switch)
            begin
                no_idle     = ($urandom_range(0, 3) == 0);
                next_switch = item_count + $urandom_range(30, 120);
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:
                begin
                    send_byte(8'($urandom_range(0, 255)));
                end
                5:
                begin
                    case ($urandom_range(0, 4))
                        0: send_byte(CH_BEL);
                        1: send_byte(CH_BS);
                        2: send_byte(CH_LF);
                        3: send_byte(CH_FF);
                        default: send_byte(CH_CR);
                    endcase
                end
                6, 7, 8, 9:
                begin
                    send_byte(CH_ESC);
                    case ($urandom_range(0, 17))
                        0: b = CH_SEVEN;
                        1: b = CH_EIGHT;
                        2: b = CH_D;
                        3: b = CH_M;
                        4: b = CH_E;
                        5: b = CH_LOWER_C;
                        6: b = CH_F;
                        7: b = CH_G;
                        8: b = CH_A;
                        9: b = CH_B;
                        10: b = CH_C;
                        11: b = CH_H;
                        12: b = CH_I;
                        13: b = CH_J;
                        14: b = CH_K;
                        15: b = CH_Z;
                        16: b = CH_LESS;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    send_byte(b);
                end
                10, 11, 12, 13, 14, 15:
                begin
                    send_csi();
                end
                16, 17:
                begin
                    send_byte(CH_ESC);
                    send_byte(CH_LPAREN);
                    if ($urandom_range(0, 5) == 0)
                    begin
                        do b = 8'($urandom_range(0, 255));
                        while (b >= CH_ZERO && b < FINAL_END);
                        send_byte(b);
                    end
                    if ($urandom_range(0, 1))
                    begin
                        send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
                    end
                    else
                    begin
                        send_byte(8'($urandom_range(FINAL_LO, 8'h7D)));
                    end
                end
                default:
                begin
                    send_byte(CH_ESC);
                    if ($urandom_range(0, 1))
                    begin
                        send_byte(CH_LBRACK);
                    end
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                    begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end
            endcase
        end
        no_idle = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_tokens
        token_word_t want;
        token_word_t got;
        if (tok_if.valid === 1'b1 && tok_if.ready === 1'b1)
        begin
            got = tok_if.data;
            if (pending_tokens.size() == 0)
            begin
                $error("token_kind: expected none, got %0h (code %0h)",
                       got.token_kind, got.token_code);
                error_count++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
                check_field("token_code", 16'(want.token_code), 16'(got.token_code));
                check_field("param_a", want.param_a, got.param_a);
                check_field("param_b", want.param_b, got.param_b);
                check_field("param_c", want.param_c, got.param_c);
                check_field("param_d", want.param_d, got.param_d);
                check_field("param_e", want.param_e, got.param_e);
                check_field("separator_count", 16'(want.separator_count),
                            16'(got.separator_count));
                check_field("private_flag", 16'(want.private_flag),
                            16'(got.private_flag));
                check_field("space_flag", 16'(want.space_flag), 16'(got.space_flag));
                check_field("vt52_active", 16'(want.vt52_active),
                            16'(got.vt52_active));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : token_sink
        int stall;
        tok_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                tok_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tok_if.ready <= 1'b1;
            do @(posedge clk); while (tok_if.valid !== 1'b1);
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        rx_if.valid        <= 1'b0;
        rx_if.data.rx_byte <= '0;
        phase         = PH_IDLE;
        vt52_mode     = 1'b0;
        clear_sequence();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_vt100_escapes();
        test_csi_params();
        test_mode_switch();
        test_random_traffic();

        rx_if.valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
